>>> rtl/scfla_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Size-class block allocator package
// Field widths, default geometry, reset sizes, opcodes and status codes.
// ----------------------------------------------------------------------------
package scfla_pkg;

  localparam int NUM_CLASSES_DEF      = 4;
  localparam int BLOCKS_PER_CLASS_DEF = 64;

  // Fixed field widths of the request and result channels.
  localparam int OPCODE_W  = 1;
  localparam int REQ_W     = 16;
  localparam int FHANDLE_W = 9;
  localparam int STATUS_W  = 3;
  localparam int HANDLE_W  = 8;
  localparam int SIZE_W    = 13;
  localparam int CLASS_W   = 2;
  localparam int LEFT_W    = 7;

  // Width of the shared compare unit. Holds a request size and any pool bound.
  localparam int KEY_W = 17;

  // Configuration registers.
  localparam int NUM_CFG_REGS = 4;
  localparam int CFG_IDX_W    = 2;

  typedef logic [SIZE_W-1:0] size_t;

  localparam size_t SIZE_A_RST = 13'd16;
  localparam size_t SIZE_B_RST = 13'd32;
  localparam size_t SIZE_C_RST = 13'd64;
  localparam size_t SIZE_D_RST = 13'd128;

  localparam logic [OPCODE_W-1:0] OP_ALLOC = 1'b0;
  localparam logic [OPCODE_W-1:0] OP_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO_SIZE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BAD_HANDLE = 3'd4;

endpackage

>>> rtl/size_class_free_list_allocator_core.sv
`timescale 1ns / 1ps
// Sequence: an accepted allocate or free searches the classes in order, then pops or pushes
//   on a hit and stages the result for the output register; an exhausted class or no fitting class
//   stages a failure, and a zero-size allocate or an out-of-range free is staged without a search.
//   A result still waiting in the output stalls the load. Requests: one at a time, a new one is
//   taken only after the last result is loaded; the single class compare unit steps through the classes one per cycle.
// Reset: synchronous, active low; a relink pass over every block follows.
// ----------------------------------------------------------------------------
// Size-class free-list allocator core
// Pops and pushes fixed-size blocks on per-class linked free lists.
// ----------------------------------------------------------------------------
module size_class_free_list_allocator_core
  import scfla_pkg::*;
#(
  parameter int NUM_CLASSES      = NUM_CLASSES_DEF,
  parameter int BLOCKS_PER_CLASS = BLOCKS_PER_CLASS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,

  // Configuration write port: one class size per register index.
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]    cfg_wdata,

  // Request channel.
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [OPCODE_W-1:0]  in_opcode,
  input  logic [REQ_W-1:0]     in_request_bytes,
  input  logic [FHANDLE_W-1:0] in_freed_handle,

  // Result channel.
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [STATUS_W-1:0]  out_status,
  output logic [HANDLE_W-1:0]  out_block_handle,
  output logic [SIZE_W-1:0]    out_granted_bytes,
  output logic [CLASS_W-1:0]   out_class_index,
  output logic [LEFT_W-1:0]    out_blocks_left
);

  // Pool geometry. Handles are class * BLOCKS_PER_CLASS + slot.
  localparam int TOTAL = NUM_CLASSES * BLOCKS_PER_CLASS;
  localparam int HW    = $clog2(TOTAL);
  localparam int SW    = $clog2(BLOCKS_PER_CLASS);
  localparam int CW    = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int NW    = $clog2(BLOCKS_PER_CLASS + 1);

  // Sequencer states.
  localparam logic [2:0] S_CLEAR  = 3'd0;  // relink pass after reset
  localparam logic [2:0] S_IDLE   = 3'd1;  // ready for a request
  localparam logic [2:0] S_SEARCH = 3'd2;  // one class compare per cycle
  localparam logic [2:0] S_POP    = 3'd3;  // link read is back, pop the head
  localparam logic [2:0] S_PUSH   = 3'd4;  // write link, push the slot
  localparam logic [2:0] S_FIN    = 3'd5;  // hand the result to the output register

  logic [2:0]        state_r, state_nxt;

  // Class size registers.
  size_t             size_r [NUM_CFG_REGS];

  // Per-class list heads and free counts. Few entries, read only at cls_r.
  logic [SW-1:0]     head_r  [NUM_CLASSES];
  logic [NW-1:0]     count_r [NUM_CLASSES];

  // Link memory: one next-slot pointer per block.
  logic [SW-1:0]     link_mem [TOTAL];
  logic [SW-1:0]     rd_data_r;
  logic [HW-1:0]     rd_addr;
  logic              mem_we;
  logic [HW-1:0]     mem_waddr;
  logic [SW-1:0]     mem_wdata;

  // Clearing pass counters.
  logic [HW-1:0]     clr_idx_r, clr_idx_nxt;
  logic [SW-1:0]     clr_slot_r, clr_slot_nxt;

  // Request context held while the sequencer works.
  logic [OPCODE_W-1:0] op_r, op_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [CW-1:0]     cls_r, cls_nxt;
  logic [HW-1:0]     base_r, base_nxt;

  // Result staging.
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [HANDLE_W-1:0] res_handle_r, res_handle_nxt;
  logic [SIZE_W-1:0]   res_granted_r, res_granted_nxt;
  logic [CLASS_W-1:0]  res_class_r, res_class_nxt;
  logic [LEFT_W-1:0]   res_left_r, res_left_nxt;

  // Output register.
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r;
  logic [HANDLE_W-1:0] out_handle_r;
  logic [SIZE_W-1:0]   out_granted_r;
  logic [CLASS_W-1:0]  out_class_r;
  logic [LEFT_W-1:0]   out_left_r;

  // Shared compare unit and its operands.
  logic [3:0]        cls_ext;
  size_t             cls_size;
  logic [KEY_W-1:0]  limit;
  logic              hit;
  logic              last_cls;
  logic [SW-1:0]     cur_head;
  logic [NW-1:0]     cur_count;
  logic [NW-1:0]     dec_count;
  logic [NW-1:0]     inc_count;
  logic [SW-1:0]     push_slot;
  logic [HW-1:0]     pop_handle;
  logic              load_out;

  // Classes beyond the fourth share the fourth configured size.
  assign cls_ext  = 4'(cls_r);
  assign cls_size = (cls_ext > 4'd3) ? size_r[3] : size_r[cls_ext[1:0]];

  // An allocate fits when bytes <= size, a free lies in this class when the
  // handle is below the next pool base. Both reduce to key < limit.
  assign limit    = (op_r == OP_ALLOC) ? (KEY_W'(cls_size) + KEY_W'(1))
                                       : (KEY_W'(base_r) + KEY_W'(BLOCKS_PER_CLASS));
  assign hit      = key_r < limit;
  assign last_cls = cls_r == CW'(NUM_CLASSES - 1);

  assign cur_head   = head_r[cls_r];
  assign cur_count  = count_r[cls_r];
  assign dec_count  = cur_count - NW'(1);
  assign inc_count  = (cur_count < NW'(BLOCKS_PER_CLASS)) ? cur_count + NW'(1) : cur_count;
  assign push_slot  = SW'(key_r - KEY_W'(base_r));
  assign pop_handle = base_r + HW'(cur_head);

  // The link of the current head is read every cycle; the search lands on the
  // class it needs, so the data is ready in the pop state.
  assign rd_addr = pop_handle;

  assign in_ready = state_r == S_IDLE;
  assign load_out = (state_r == S_FIN) && (!out_valid_r || out_ready);

  // Link memory write: relink pass, or a push of a freed block.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_idx_r;
    mem_wdata = (clr_slot_r == '0) ? '0 : clr_slot_r - SW'(1);
    if (state_r == S_CLEAR) begin
      mem_we = 1'b1;
    end else if (state_r == S_PUSH) begin
      mem_we    = 1'b1;
      mem_waddr = key_r[HW-1:0];
      mem_wdata = cur_head;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      link_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= link_mem[rd_addr];
  end

  // Sequencer.
  always_comb begin
    state_nxt       = state_r;
    clr_idx_nxt     = clr_idx_r;
    clr_slot_nxt    = clr_slot_r;
    op_nxt          = op_r;
    key_nxt         = key_r;
    cls_nxt         = cls_r;
    base_nxt        = base_r;
    res_status_nxt  = res_status_r;
    res_handle_nxt  = res_handle_r;
    res_granted_nxt = res_granted_r;
    res_class_nxt   = res_class_r;
    res_left_nxt    = res_left_r;

    case (state_r)
      S_CLEAR: begin
        clr_idx_nxt  = clr_idx_r + HW'(1);
        clr_slot_nxt = (clr_slot_r == SW'(BLOCKS_PER_CLASS - 1)) ? '0 : clr_slot_r + SW'(1);
        if (clr_idx_r == HW'(TOTAL - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          op_nxt          = in_opcode;
          cls_nxt         = '0;
          base_nxt        = '0;
          res_status_nxt  = ST_OK;
          res_handle_nxt  = '0;
          res_granted_nxt = '0;
          res_class_nxt   = '0;
          res_left_nxt    = '0;
          if (in_opcode == OP_ALLOC) begin
            key_nxt = KEY_W'(in_request_bytes);
            if (in_request_bytes == '0) begin
              res_status_nxt = ST_ZERO_SIZE;
              state_nxt      = S_FIN;
            end else begin
              state_nxt = S_SEARCH;
            end
          end else begin
            key_nxt = KEY_W'(in_freed_handle);
            if (KEY_W'(in_freed_handle) >= KEY_W'(TOTAL)) begin
              res_status_nxt = ST_BAD_HANDLE;
              state_nxt      = S_FIN;
            end else begin
              state_nxt = S_SEARCH;
            end
          end
        end
      end
      S_SEARCH: begin
        if (hit) begin
          if (op_r == OP_FREE) begin
            state_nxt = S_PUSH;
          end else if (cur_count == '0) begin
            res_status_nxt = ST_EXHAUSTED;
            res_class_nxt  = CLASS_W'(cls_r);
            state_nxt      = S_FIN;
          end else begin
            state_nxt = S_POP;
          end
        end else if (last_cls) begin
          res_status_nxt = ST_TOO_LARGE;
          state_nxt      = S_FIN;
        end else begin
          cls_nxt  = cls_r + CW'(1);
          base_nxt = base_r + HW'(BLOCKS_PER_CLASS);
        end
      end
      S_POP: begin
        res_handle_nxt  = HANDLE_W'(pop_handle);
        res_granted_nxt = cls_size;
        res_class_nxt   = CLASS_W'(cls_r);
        res_left_nxt    = LEFT_W'(dec_count);
        state_nxt       = S_FIN;
      end
      S_PUSH: begin
        res_handle_nxt  = HANDLE_W'(key_r);
        res_granted_nxt = cls_size;
        res_class_nxt   = CLASS_W'(cls_r);
        res_left_nxt    = LEFT_W'(inc_count);
        state_nxt       = S_FIN;
      end
      S_FIN: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // The output register frees up when the consumer takes the result.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_idx_r   <= '0;
      clr_slot_r  <= '0;
      op_r        <= OP_ALLOC;
      cls_r       <= '0;
      base_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      clr_slot_r  <= clr_slot_nxt;
      op_r        <= op_nxt;
      cls_r       <= cls_nxt;
      base_r      <= base_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    key_r         <= key_nxt;
    res_status_r  <= res_status_nxt;
    res_handle_r  <= res_handle_nxt;
    res_granted_r <= res_granted_nxt;
    res_class_r   <= res_class_nxt;
    res_left_r    <= res_left_nxt;
    if (load_out) begin
      out_status_r  <= res_status_r;
      out_handle_r  <= res_handle_r;
      out_granted_r <= res_granted_r;
      out_class_r   <= res_class_r;
      out_left_r    <= res_left_r;
    end
  end

  // Class size registers; every index names one of the four registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r[0] <= SIZE_A_RST;
      size_r[1] <= SIZE_B_RST;
      size_r[2] <= SIZE_C_RST;
      size_r[3] <= SIZE_D_RST;
    end else if (cfg_we) begin
      size_r[cfg_index] <= cfg_wdata;
    end
  end

  // List heads and free counts. After reset every class hands out its
  // highest slot first.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        head_r[c]  <= SW'(BLOCKS_PER_CLASS - 1);
        count_r[c] <= NW'(BLOCKS_PER_CLASS);
      end
    end else if (state_r == S_POP) begin
      head_r[cls_r]  <= rd_data_r;
      count_r[cls_r] <= dec_count;
    end else if (state_r == S_PUSH) begin
      head_r[cls_r]  <= push_slot;
      count_r[cls_r] <= inc_count;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_block_handle  = out_handle_r;
  assign out_granted_bytes = out_granted_r;
  assign out_class_index   = out_class_r;
  assign out_blocks_left   = out_left_r;

`ifndef SYNTHESIS
  // A pop takes exactly one block from the class it searched.
  a_pop_decrements: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POP) |=> (count_r[cls_r] == NW'($past(count_r[cls_r]) - NW'(1))))
    else $error("free count did not drop by one on a pop");

  // An exhausted status is only given for a class with no free block.
  a_exhausted_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && res_status_r == ST_EXHAUSTED) |-> (count_r[cls_r] == '0))
    else $error("exhausted status on a class with free blocks");

  // Failures carry no handle and no granted size.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && res_status_r != ST_OK) |->
      (res_handle_r == '0 && res_granted_r == '0))
    else $error("failed request reports a handle or size");

  // The class search never steps past the last pool.
  a_search_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEARCH) |-> (4'(cls_r) <= 4'(NUM_CLASSES - 1)))
    else $error("class search ran past the last class");
`endif

endmodule
